/* sv/urg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urg_pkg
// Shared types, constants and the fraction-to-single helper of the uniform
// random generator.
// ----------------------------------------------------------------------------
package urg_pkg;

    // field and word widths
    localparam int SEED_W  = 64;
    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 23;
    localparam int FLOAT_W = 30;
    localparam int EXPO_W  = FLOAT_W - FRAC_W;
    localparam int LZ_W    = 5;

    // seeding mix constants
    localparam logic [SEED_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [SEED_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam logic [SEED_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;

    // biased exponent of the largest value below one
    localparam logic [EXPO_W-1:0] EXPO_TOP = 7'd126;

    // controller states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_START = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_M0    = 9'b000001000,
        ST_M1    = 9'b000010000,
        ST_M2    = 9'b000100000,
        ST_M3    = 9'b001000000,
        ST_STORE = 9'b010000000,
        ST_DRAW  = 9'b100000000
    } urg_state_t;

    // source of the mix operand
    typedef enum logic [1:0] {
        Z_BASE      = 2'd0,
        Z_BASE_GOLD = 2'd1,
        Z_ACC       = 2'd2
    } urg_zsel_t;

    // which 32x32 partial product to form
    typedef enum logic [1:0] {
        MUL_LL = 2'd0,
        MUL_HL = 2'd1,
        MUL_LH = 2'd2
    } urg_mulsel_t;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_SET    = 2'd1,
        ACC_ADD_HI = 2'd2
    } urg_accop_t;

    // commands from controller to datapath
    typedef struct packed {
        logic        base_load;
        logic        base_zero;
        logic        z_load;
        urg_zsel_t   z_sel;
        urg_mulsel_t mul_sel;
        logic        k_sel;
        urg_accop_t  acc_op;
        logic        store;
        logic        store_half;
        logic        draw;
    } urg_cmd_t;

    // exact single encoding of frac / 2^23
    function automatic logic [FLOAT_W-1:0] float_of_fraction(input logic [FRAC_W-1:0] frac);
        logic [LZ_W-1:0]   lz;
        logic              found;
        logic [FRAC_W-1:0] mant;
        logic [EXPO_W-1:0] expo;
        lz    = '0;
        found = 1'b0;
        // leading zero count
        for (int i = FRAC_W - 1; i >= 0; i--) begin
            if (!found && frac[i]) begin
                lz    = LZ_W'(FRAC_W - 1 - i);
                found = 1'b1;
            end
        end
        mant = frac << (lz + LZ_W'(1));
        expo = EXPO_TOP - EXPO_W'(lz);
        if (!found) begin
            return '0;
        end
        return {expo, mant};
    endfunction

endpackage

/* sv/urg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urg_ctrl
// Controller: sequences the seeding mixes, the draw handshake and the
// output valid flag.
// ----------------------------------------------------------------------------
module urg_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_restart,
    output logic            m_valid,
    input  logic            m_ready,
    output urg_pkg::urg_cmd_t cmd
);
    import urg_pkg::*;

    urg_state_t state_reg, state_next;
    logic       round_reg, round_next;
    logic       half_reg, half_next;
    logic       init_reg, init_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       accept;

    // output slot can take a new beat
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        half_next      = half_reg;
        init_next      = init_reg;
        cmd            = '0;
        cmd.z_sel      = round_reg ? Z_ACC : (half_reg ? Z_BASE_GOLD : Z_BASE);
        cmd.mul_sel    = MUL_LL;
        cmd.acc_op     = ACC_HOLD;
        cmd.k_sel      = round_reg;
        cmd.store_half = half_reg;
        cmd.base_zero  = init_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_restart) begin
                        state_next = ST_START;
                    end else begin
                        cmd.draw = 1'b1;
                    end
                end
            end
            ST_START: begin
                cmd.base_load = 1'b1;
                round_next    = 1'b0;
                half_next     = 1'b0;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.z_load = 1'b1;
                state_next = ST_M0;
            end
            ST_M0: begin
                cmd.mul_sel = MUL_LL;
                state_next  = ST_M1;
            end
            ST_M1: begin
                cmd.mul_sel = MUL_HL;
                cmd.acc_op  = ACC_SET;
                state_next  = ST_M2;
            end
            ST_M2: begin
                cmd.mul_sel = MUL_LH;
                cmd.acc_op  = ACC_ADD_HI;
                state_next  = ST_M3;
            end
            ST_M3: begin
                cmd.acc_op = ACC_ADD_HI;
                if (!round_reg) begin
                    round_next = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (!half_reg) begin
                    half_next  = 1'b1;
                    round_next = 1'b0;
                    state_next = ST_LOAD;
                end else if (init_reg) begin
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (out_free) begin
                    cmd.draw   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        if (cmd.draw) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_START;
            round_reg   <= 1'b0;
            half_reg    <= 1'b0;
            init_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            half_reg    <= half_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // checks
    a_reset_seeds: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == ST_START && init_reg))
        else $error("reset does not start the seeding pass");

    a_restart_seeds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_restart) |=> (state_reg == ST_START))
        else $error("restart beat did not start reseeding");

    a_draw_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw |-> out_free)
        else $error("draw overwrites an untaken result");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while seeding");

    a_store_after_b: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> ($past(state_reg) == ST_M3 && round_reg))
        else $error("state words stored before the second multiply");

endmodule

/* sv/urg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urg_datapath
// Datapath: seed register, seeding mixer with one shared 32x32 multiplier,
// generator words, draw update and output registers.
// ----------------------------------------------------------------------------
module urg_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [urg_pkg::SEED_W-1:0]    cfg_seed,
    input  urg_pkg::urg_cmd_t             cmd,
    output logic [urg_pkg::FRAC_W-1:0]    m_fraction,
    output logic [urg_pkg::FLOAT_W-1:0]   m_float_bits
);
    import urg_pkg::*;

    logic [SEED_W-1:0]  seed_reg;
    logic [SEED_W-1:0]  base_reg;
    logic [SEED_W-1:0]  z_reg;
    logic [SEED_W-1:0]  z_next;
    logic [SEED_W-1:0]  base_gold;
    logic [SEED_W-1:0]  acc_reg;
    logic [SEED_W-1:0]  prod_reg;
    logic [SEED_W-1:0]  mix_out;
    logic [SEED_W-1:0]  k_val;
    logic [WORD_W-1:0]  mul_a;
    logic [WORD_W-1:0]  mul_b;
    logic [WORD_W-1:0]  s0_reg, s1_reg, s2_reg, s3_reg;
    logic [WORD_W-1:0]  n0, n1, n2, n3, t_word, x2, x3;
    logic [WORD_W-1:0]  sum;
    logic [FRAC_W-1:0]  frac;
    logic [FRAC_W-1:0]  frac_reg;
    logic [FLOAT_W-1:0] float_reg;

    // seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_valid) begin
            seed_reg <= cfg_seed;
        end
    end

    // mix operand select
    assign base_gold = base_reg + GOLDEN_STEP;
    always_comb begin
        case (cmd.z_sel)
            Z_BASE:      z_next = base_reg ^ (base_reg >> 30);
            Z_BASE_GOLD: z_next = base_gold ^ (base_gold >> 30);
            Z_ACC:       z_next = acc_reg ^ (acc_reg >> 27);
            default:     z_next = acc_reg ^ (acc_reg >> 27);
        endcase
    end

    // partial product operands
    assign k_val = cmd.k_sel ? MIX_MUL_B : MIX_MUL_A;
    always_comb begin
        case (cmd.mul_sel)
            MUL_LL: begin
                mul_a = z_reg[WORD_W-1:0];
                mul_b = k_val[WORD_W-1:0];
            end
            MUL_HL: begin
                mul_a = z_reg[SEED_W-1:WORD_W];
                mul_b = k_val[WORD_W-1:0];
            end
            MUL_LH: begin
                mul_a = z_reg[WORD_W-1:0];
                mul_b = k_val[SEED_W-1:WORD_W];
            end
            default: begin
                mul_a = z_reg[WORD_W-1:0];
                mul_b = k_val[WORD_W-1:0];
            end
        endcase
    end

    assign mix_out = acc_reg ^ (acc_reg >> 31);

    // seeding mixer registers
    always_ff @(posedge aclk) begin
        if (cmd.base_load) begin
            base_reg <= cmd.base_zero ? '0 : seed_reg;
        end
        if (cmd.z_load) begin
            z_reg <= z_next;
        end
        // full 64-bit product of two 32-bit operands
        prod_reg <= {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
        case (cmd.acc_op)
            ACC_SET:    acc_reg <= prod_reg;
            ACC_ADD_HI: acc_reg <= acc_reg + {prod_reg[WORD_W-1:0], {WORD_W{1'b0}}};
            default:    acc_reg <= acc_reg;
        endcase
    end

    // xoshiro128+ step
    assign t_word = s1_reg << 9;
    assign x2     = s2_reg ^ s0_reg;
    assign x3     = s3_reg ^ s1_reg;
    assign n1     = s1_reg ^ x2;
    assign n0     = s0_reg ^ x3;
    assign n2     = x2 ^ t_word;
    assign n3     = {x3[WORD_W-12:0], x3[WORD_W-1:WORD_W-11]};

    assign sum  = s0_reg + s3_reg;
    assign frac = sum[WORD_W-1:WORD_W-FRAC_W];

    // generator words
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            if (!cmd.store_half) begin
                s0_reg <= mix_out[SEED_W-1:WORD_W];
                s1_reg <= mix_out[WORD_W-1:0];
            end else begin
                s2_reg <= mix_out[SEED_W-1:WORD_W];
                s3_reg <= mix_out[WORD_W-1:0];
            end
        end else if (cmd.draw) begin
            s0_reg <= n0;
            s1_reg <= n1;
            s2_reg <= n2;
            s3_reg <= n3;
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.draw) begin
            frac_reg  <= frac;
            float_reg <= float_of_fraction(frac);
        end
    end

    assign m_fraction   = frac_reg;
    assign m_float_bits = float_reg;

endmodule

/* sv/uniform_random_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_random_generator_unit
// xoshiro128+ uniform source with SplitMix64 seeding; each beat in gives
// one 0.23 fraction and its single-precision encoding.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  s_       | in        | s_valid / s_ready   | s_restart
//  m_       | out       | m_valid / m_ready   | m_fraction, m_float_bits
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_seed (64-bit seed)
//
//  A draw beat is taken straight from idle; its result is registered at the
//  accepting edge and is valid in the next cycle; draws follow back to
//  back while the result side keeps up.
//  A restart beat reseeds first: two SplitMix64 mixes on one shared 32x32
//  multiplier, then the draw.
//  After reset the same seeding pass runs with seed zero; s_ready
//  stays low until it ends. cfg_ready is always high.
//  A stalled result holds the input side off until it is taken or taken
//  in the same cycle.
// ----------------------------------------------------------------------------
module uniform_random_generator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [urg_pkg::SEED_W-1:0]    cfg_seed,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [urg_pkg::FRAC_W-1:0]    m_fraction,
    output logic [urg_pkg::FLOAT_W-1:0]   m_float_bits
);
    import urg_pkg::*;

    urg_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // sequencing
    urg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    // arithmetic and state
    urg_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_seed     (cfg_seed),
        .cmd          (cmd),
        .m_fraction   (m_fraction),
        .m_float_bits (m_float_bits)
    );

endmodule

/* tb/tb_uniform_random_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uniform_random_generator_unit
// Self-checking bench for the uniform random generator. A scripted run of
// seed loads and restarts is followed by random phases of draws. Every
// accepted draw is predicted by an in-bench xoshiro128+ / SplitMix64 model
// and compared field by field with the result beats, in order.
// ----------------------------------------------------------------------------
module tb_uniform_random_generator_unit;

    import urg_pkg::*;

    localparam int RANDOM_DRAWS = 1630;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;

    // one scripted step: optional seed load, then one draw
    typedef struct packed {
        logic              load;
        logic [SEED_W-1:0] seed;
        logic              restart;
    } script_row_t;

    // one predicted result beat
    typedef struct {
        logic [FRAC_W-1:0]  fraction;
        logic [FLOAT_W-1:0] float_bits;
    } draw_t;

    localparam int SCRIPT_LEN = 20;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0},  // first draws after the reset seeding
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0},
        '{1'b0, 64'h0000_0000_0000_0000, 1'b1},  // restart from seed zero
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0},
        '{1'b1, 64'hffff_ffff_ffff_ffff, 1'b0},  // new seed, sequence carries on
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0},
        '{1'b0, 64'h0000_0000_0000_0000, 1'b1},  // restart from all ones
        '{1'b0, 64'h0000_0000_0000_0000, 1'b1},  // back-to-back restarts
        '{1'b1, 64'h61c8_8646_80b5_83eb, 1'b1},  // seed plus golden step wraps to zero
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0},
        '{1'b1, GOLDEN_STEP,             1'b1},
        '{1'b1, 64'h0000_0000_0000_0001, 1'b1},
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0},
        '{1'b1, 64'h8000_0000_0000_0000, 1'b1},
        '{1'b1, 64'h0000_0000_ffff_ffff, 1'b1},
        '{1'b1, 64'hffff_ffff_0000_0000, 1'b1},
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0},
        '{1'b1, 64'h0000_0000_0000_0000, 1'b1},  // back to seed zero
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0},
        '{1'b0, 64'h0000_0000_0000_0000, 1'b0}
    };

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SEED_W-1:0]   cfg_seed;
    logic                s_valid;
    logic                s_ready;
    logic                s_restart;
    logic                m_valid;
    logic                m_ready;
    logic [FRAC_W-1:0]   m_fraction;
    logic [FLOAT_W-1:0]  m_float_bits;

    // bench model of the generator
    logic [SEED_W-1:0]   seed_now;
    logic [WORD_W-1:0]   gen_word [4];
    draw_t               draws_due [$];
    draw_t               predicted;
    draw_t               oldest;

    int                  mismatches;
    int                  draws_sent;
    int                  draws_seen;
    bit                  calm;
    bit                  hold_req;

    uniform_random_generator_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_seed     (cfg_seed),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fraction   (m_fraction),
        .m_float_bits (m_float_bits)
    );

    // clock, 2 ns period
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // splitmix64 finalizer
    function automatic logic [SEED_W-1:0] splitmix(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] z;
        z = (v ^ (v >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // expand the seed into the four state words, upper half first
    function automatic void expand_seed();
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
        a = splitmix(seed_now);
        b = splitmix(seed_now + GOLDEN_STEP);
        gen_word[0] = a[63:32];
        gen_word[1] = a[31:0];
        gen_word[2] = b[63:32];
        gen_word[3] = b[31:0];
    endfunction

    // single-precision bits of f / 2^23, always exact
    function automatic logic [FLOAT_W-1:0] single_of(input logic [FRAC_W-1:0] f);
        int                p;
        logic [FRAC_W-1:0] m;
        if (f == '0) begin
            return '0;
        end
        p = FRAC_W - 1;
        while (!f[p]) p--;
        m = f << (FRAC_W - p);
        return {EXPO_W'(104 + p), m};
    endfunction

    // reseed on restart, then one draw and one xoshiro128+ step
    function automatic draw_t draw_next(input logic restart);
        draw_t             d;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] t;
        if (restart) begin
            expand_seed();
        end
        sum          = gen_word[0] + gen_word[3];
        d.fraction   = sum[WORD_W-1:WORD_W-FRAC_W];
        d.float_bits = single_of(d.fraction);
        t            = gen_word[1] << 9;
        gen_word[2]  = gen_word[2] ^ gen_word[0];
        gen_word[3]  = gen_word[3] ^ gen_word[1];
        gen_word[1]  = gen_word[1] ^ gen_word[2];
        gen_word[0]  = gen_word[0] ^ gen_word[3];
        gen_word[2]  = gen_word[2] ^ t;
        gen_word[3]  = {gen_word[3][20:0], gen_word[3][31:21]};
        return d;
    endfunction

    // idle length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // watch all three channels; results are checked before new draws are queued
    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_now = '0;
            expand_seed();
            draws_due.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_valid && m_ready) begin
                draws_seen++;
                if (draws_due.size() == 0) begin
                    $error("result beat with no draw outstanding");
                    mismatches++;
                end else begin
                    oldest = draws_due.pop_front();
                    if (m_fraction !== oldest.fraction) begin
                        $error("fraction: expected %h, got %h", oldest.fraction, m_fraction);
                        mismatches++;
                    end
                    if (m_float_bits !== oldest.float_bits) begin
                        $error("float_bits: expected %h, got %h",
                               oldest.float_bits, m_float_bits);
                        mismatches++;
                    end
                end
            end
            // seed register write
            if (cfg_valid && cfg_ready) begin
                seed_now = cfg_seed;
            end
            // accepted draw request
            if (s_valid && s_ready) begin
                predicted = draw_next(s_restart);
                draws_due.push_back(predicted);
            end
        end
    end

    // result side: random stalls, calm stretches, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end
        end
    end

    // offer one draw beat and wait for it to be taken
    task automatic offer_draw(input logic restart);
        int gap;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        draws_sent++;
    endtask

    // write the seed once the block is idle and every result is back
    task automatic load_seed(input logic [SEED_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (draws_due.size() != 0 || !s_ready) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_seed  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [SEED_W-1:0] new_seed;
        int                phase_len;
        bit                hold_done;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_seed   = '0;
        s_valid    = 1'b0;
        s_restart  = 1'b0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        mismatches = 0;
        draws_sent = 0;
        draws_seen = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // scripted part
        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].load) begin
                load_seed(SCRIPT[i].seed);
            end
            offer_draw(SCRIPT[i].restart);
        end

        // random phases: mostly long runs of one sequence, restarts now and then
        while (draws_sent < SCRIPT_LEN + RANDOM_DRAWS) begin
            phase_len = $urandom_range(20, 120);
            calm      = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0: new_seed = '0;
                    1: new_seed = '1;
                    2: new_seed = 64'h61c8_8646_80b5_83eb;
                    3: new_seed = {32'h0, $urandom};
                    default: new_seed = {$urandom, $urandom};
                endcase
                load_seed(new_seed);
            end
            // one phase where the result side stops while draws keep coming
            if (!hold_done && draws_sent >= 600) begin
                phase_len = 150;
                calm      = 1'b1;
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            for (int k = 0; k < phase_len; k++) begin
                offer_draw(k == 0 ? ($urandom_range(0, 3) != 0)
                                  : ($urandom_range(0, 15) == 0));
            end
        end
        s_valid <= 1'b0;

        // drain, then let any stray beat show up
        while (draws_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* uniform_random_generator_unit.f */
sv/urg_pkg.sv
sv/urg_ctrl.sv
sv/urg_datapath.sv
sv/uniform_random_generator_unit.sv
tb/tb_uniform_random_generator_unit.sv
